// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the blit pixel RTL. Each macro samples on clk
// and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define AST_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AST_IMPLY(name, ante, cons, msg)
`define AST_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/abp_pkg.sv -----
// ---------------------------------------------------------------------------
// abp_pkg
// Shared types, constants and helpers of the ARGB alpha blit pixel pipeline.
// ---------------------------------------------------------------------------
package abp_pkg;

    localparam int DIM_W   = 13;   // dimension / offset register width
    localparam int COORD_W = 12;   // source coordinate width
    localparam int ADDR_W  = 24;   // linear destination address width
    localparam int PIX_W   = 32;   // ARGB pixel width
    localparam int PROD_W  = 2 * DIM_W;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_DEST_WIDTH   = 3'd0,
        REG_DEST_HEIGHT  = 3'd1,
        REG_OFFSET_X     = 3'd2,
        REG_OFFSET_Y     = 3'd3,
        REG_OPACITY      = 3'd4
    } abp_reg_t;

    // per-stage load enables handed to the datapath units
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } abp_adv_t;

    // floor(x / 255) for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return sum[15:8];
    endfunction

endpackage

// ----- hw/rtl/abp_geom.sv -----
// ---------------------------------------------------------------------------
// abp_geom
// Placement, clipping and linear address of one pixel, three register stages.
// ---------------------------------------------------------------------------
module abp_geom (
    input  logic                         clk,
    input  abp_pkg::abp_adv_t            adv,
    input  logic [abp_pkg::COORD_W-1:0]  src_col,
    input  logic [abp_pkg::COORD_W-1:0]  src_row,
    input  logic [abp_pkg::DIM_W-1:0]    width_sat,
    input  logic [abp_pkg::DIM_W-1:0]    height_sat,
    input  logic [abp_pkg::DIM_W-1:0]    offset_x,
    input  logic [abp_pkg::DIM_W-1:0]    offset_y,
    output logic                         in_box,
    output logic [abp_pkg::ADDR_W-1:0]   addr
);
    import abp_pkg::*;

    logic signed [DIM_W:0] tx;
    logic signed [DIM_W:0] ty;
    logic                  in_next;

    logic               in1_reg;
    logic [DIM_W-1:0]   tx1_reg;
    logic [DIM_W-1:0]   ty1_reg;
    logic [DIM_W-1:0]   w1_reg;

    logic               in2_reg;
    logic [DIM_W-1:0]   tx2_reg;
    logic [PROD_W-1:0]  prod2_reg;

    logic               in3_reg;
    logic [ADDR_W-1:0]  addr3_reg;

    // place the source coordinate and test it against the destination box
    always_comb
    begin
        tx = $signed({offset_x[DIM_W-1], offset_x})
           + $signed({2'b00, src_col});
        ty = $signed({offset_y[DIM_W-1], offset_y})
           + $signed({2'b00, src_row});
        in_next = !tx[DIM_W] && !ty[DIM_W]
               && (tx[DIM_W-1:0] < width_sat) && (ty[DIM_W-1:0] < height_sat);
    end

    // stage 1: clip result and target coordinates
    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            in1_reg <= in_next;
            tx1_reg <= tx[DIM_W-1:0];
            ty1_reg <= ty[DIM_W-1:0];
            w1_reg  <= width_sat;
        end
    end

    // stage 2: row times width
    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            in2_reg   <= in1_reg;
            tx2_reg   <= tx1_reg;
            prod2_reg <= ty1_reg * w1_reg;
        end
    end

    // stage 3: add the column, wrap to the address width
    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            in3_reg   <= in2_reg;
            addr3_reg <= prod2_reg[ADDR_W-1:0] + {{(ADDR_W-DIM_W){1'b0}}, tx2_reg};
        end
    end

    assign in_box = in3_reg;
    assign addr   = addr3_reg;

endmodule

// ----- hw/rtl/abp_blend.sv -----
// ---------------------------------------------------------------------------
// abp_blend
// Global alpha scaling and 8-bit source-over blend, three register stages
// followed by the final divide and select.
// ---------------------------------------------------------------------------
module abp_blend (
    input  logic                       clk,
    input  abp_pkg::abp_adv_t          adv,
    input  logic [abp_pkg::PIX_W-1:0]  src_argb,
    input  logic [abp_pkg::PIX_W-1:0]  dst_pixel,
    input  logic [7:0]                 opacity,
    output logic [abp_pkg::PIX_W-1:0]  blend_pixel
);
    import abp_pkg::*;

    logic [15:0]       prod1_reg;
    logic              scale1_reg;
    logic [PIX_W-1:0]  src1_reg;
    logic [PIX_W-1:0]  dst1_reg;

    logic [7:0]        a2_reg;
    logic [23:0]       rgb2_reg;
    logic [PIX_W-1:0]  dst2_reg;

    logic [7:0]        a3_reg;
    logic [23:0]       rgb3_reg;
    logic [PIX_W-1:0]  dst3_reg;
    logic [15:0]       sum_r3_reg;
    logic [15:0]       sum_g3_reg;
    logic [15:0]       sum_b3_reg;

    logic [7:0]        inv2;

    // stage 1: source alpha times global alpha
    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            prod1_reg  <= src_argb[31:24] * opacity;
            scale1_reg <= (opacity != ALPHA_OPAQUE);
            src1_reg   <= src_argb;
            dst1_reg   <= dst_pixel;
        end
    end

    // stage 2: pick scaled or original alpha
    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            a2_reg   <= scale1_reg ? div255(prod1_reg) : src1_reg[31:24];
            rgb2_reg <= src1_reg[23:0];
            dst2_reg <= dst1_reg;
        end
    end

    assign inv2 = ALPHA_OPAQUE - a2_reg;

    // stage 3: weighted channel sums
    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            a3_reg     <= a2_reg;
            rgb3_reg   <= rgb2_reg;
            dst3_reg   <= dst2_reg;
            sum_r3_reg <= rgb2_reg[23:16] * a2_reg + dst2_reg[23:16] * inv2;
            sum_g3_reg <= rgb2_reg[15:8]  * a2_reg + dst2_reg[15:8]  * inv2;
            sum_b3_reg <= rgb2_reg[7:0]   * a2_reg + dst2_reg[7:0]   * inv2;
        end
    end

    // divide the sums and select the transparent / opaque / blended case
    always_comb
    begin
        if (a3_reg == ALPHA_CLEAR)
            blend_pixel = dst3_reg;
        else if (a3_reg == ALPHA_OPAQUE)
            blend_pixel = {a3_reg, rgb3_reg};
        else
            blend_pixel = {ALPHA_OPAQUE, div255(sum_r3_reg), div255(sum_g3_reg),
                           div255(sum_b3_reg)};
    end

endmodule

// ----- hw/rtl/argb_alpha_blit_pixel_top.sv -----
// Throughput: one word per cycle while the output side is ready; the
// four-stage pipeline with a per-stage valid bit advances any stage whose
// successor is empty or moving.
// Reset: rst_n clears all valid bits and loads the configuration defaults
// (640 x 480, zero offset, global alpha 255); no clearing pass is needed.
// ---------------------------------------------------------------------------
// argb_alpha_blit_pixel_top
// Source-over ARGB blit of one pixel per word with placement and clipping.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module argb_alpha_blit_pixel_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // src_col[11:0], src_row[23:12], src_argb[55:24],
                                   // dst_pixel[87:56]
    input  logic        s_tlast,   // last_pixel
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // dest_address[23:0], out_pixel[55:24]
    output logic [0:0]  m_tuser,   // write_enable[0]
    output logic        m_tlast    // out_last
);
    import abp_pkg::*;

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0] dest_width_reg;
    logic [DIM_W-1:0] dest_height_reg;
    logic [DIM_W-1:0] offset_x_reg;
    logic [DIM_W-1:0] offset_y_reg;
    logic [7:0]       opacity_reg;

    logic [DIM_W-1:0] width_sat;
    logic [DIM_W-1:0] height_sat;

    logic [3:0] valid_reg;
    logic [3:0] rdy;
    logic [2:0] last_reg;
    abp_adv_t   adv;

    logic              in_box3;
    logic [ADDR_W-1:0] addr3;
    logic [PIX_W-1:0]  pix3;

    logic              we_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              last_out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_width_reg  <= DIM_W'(640);
            dest_height_reg <= DIM_W'(480);
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            opacity_reg     <= ALPHA_OPAQUE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEST_WIDTH:   dest_width_reg  <= cfg_data;
                REG_DEST_HEIGHT:  dest_height_reg <= cfg_data;
                REG_OFFSET_X:     offset_x_reg    <= cfg_data;
                REG_OFFSET_Y:     offset_y_reg    <= cfg_data;
                REG_OPACITY:      opacity_reg     <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // saturate the dimensions to the supported maximum
    assign width_sat  = (32'(dest_width_reg) > 32'(MAX_DIM))  ? MAX_DIM_V : dest_width_reg;
    assign height_sat = (32'(dest_height_reg) > 32'(MAX_DIM)) ? MAX_DIM_V : dest_height_reg;

    // a stage loads when it is empty or its word moves on
    assign rdy[3] = !valid_reg[3] || m_tready;
    assign rdy[2] = !valid_reg[2] || rdy[3];
    assign rdy[1] = !valid_reg[1] || rdy[2];
    assign rdy[0] = !valid_reg[0] || rdy[1];

    assign adv.s1 = rdy[0];
    assign adv.s2 = rdy[1];
    assign adv.s3 = rdy[2];

    assign s_tready = rdy[0];

    // advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (rdy[0]) valid_reg[0] <= s_tvalid;
            if (rdy[1]) valid_reg[1] <= valid_reg[0];
            if (rdy[2]) valid_reg[2] <= valid_reg[1];
            if (rdy[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    // carry the frame marker alongside the datapath
    always_ff @(posedge clk)
    begin
        if (rdy[0]) last_reg[0] <= s_tlast;
        if (rdy[1]) last_reg[1] <= last_reg[0];
        if (rdy[2]) last_reg[2] <= last_reg[1];
    end

    abp_geom u_geom (
        .clk        (clk),
        .adv        (adv),
        .src_col    (s_tdata[11:0]),
        .src_row    (s_tdata[23:12]),
        .width_sat  (width_sat),
        .height_sat (height_sat),
        .offset_x   (offset_x_reg),
        .offset_y   (offset_y_reg),
        .in_box     (in_box3),
        .addr       (addr3)
    );

    abp_blend u_blend (
        .clk          (clk),
        .adv          (adv),
        .src_argb     (s_tdata[55:24]),
        .dst_pixel    (s_tdata[87:56]),
        .opacity      (opacity_reg),
        .blend_pixel  (pix3)
    );

    // output register: zero the address and pixel of clipped words
    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            we_reg       <= in_box3;
            addr_reg     <= in_box3 ? addr3 : '0;
            pix_reg      <= in_box3 ? pix3  : '0;
            last_out_reg <= last_reg[2];
        end
    end

    assign m_tvalid   = valid_reg[3];
    assign m_tdata    = {pix_reg, addr_reg};
    assign m_tuser[0] = we_reg;
    assign m_tlast    = last_out_reg;

    `AST_IMPLY(a_clip_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "clipped word not zeroed")
    `AST_IMPLY(a_empty_ready, !m_tvalid, s_tready, "input stalled with empty output stage")
    `AST_IMPLY(a_full_stall, (&valid_reg) && !m_tready, !s_tready, "input taken into full pipe")
    `AST_NEXT(a_stage_hold, valid_reg[0] && !rdy[1], valid_reg[0], "stalled stage 1 word lost")

endmodule

// ----- tb/sv/argb_alpha_blit_pixel_checker.sv -----
// ----------------------------------------------------------------------------
// ARGB alpha blit pixel checker
// Watches the configuration port and both stream channels of the blit pixel
// pipeline. Keeps its own copy of the registers, predicts the write word for
// every accepted pixel and compares each output word, field by field, with
// the oldest prediction.
// ----------------------------------------------------------------------------
module argb_alpha_blit_pixel_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,   // src_col[11:0], src_row[23:12], src_argb[55:24],
                                   // dst_pixel[87:56]
    input  logic        s_tlast,   // last_pixel
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // dest_address[23:0], out_pixel[55:24]
    input  logic [0:0]  m_tuser,   // write_enable[0]
    input  logic        m_tlast,   // out_last
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import abp_pkg::*;

    localparam int DIM_LIMIT  = 4096;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic        wr_en;
        logic [23:0] addr;
        logic [31:0] pixel;
        logic        last;
    } fb_write_t;

    // shadow copy of the configuration registers
    logic [12:0]        width_reg;
    logic [12:0]        height_reg;
    logic signed [12:0] off_x;
    logic signed [12:0] off_y;
    logic [7:0]         opacity;

    fb_write_t pending_writes[$];
    fb_write_t want;
    fb_write_t got;

    // place, clip, scale alpha and blend one pixel over the destination
    function automatic fb_write_t blend_write(input logic [87:0] word, input logic last);
        fb_write_t   res;
        int          w;
        int          h;
        int          tx;
        int          ty;
        int          a;
        int          s;
        int          d;
        logic [31:0] src;
        logic [31:0] dst;
        src       = word[55:24];
        dst       = word[87:56];
        w         = (width_reg > DIM_LIMIT) ? DIM_LIMIT : int'(width_reg);
        h         = (height_reg > DIM_LIMIT) ? DIM_LIMIT : int'(height_reg);
        tx        = int'(off_x) + int'(word[11:0]);
        ty        = int'(off_y) + int'(word[23:12]);
        res.wr_en = 1'b0;
        res.addr  = '0;
        res.pixel = '0;
        res.last  = last;
        if (tx < 0 || ty < 0 || tx >= w || ty >= h)
            return res;
        a = int'(src[31:24]);
        if (opacity != ALPHA_OPAQUE)
            a = (a * int'(opacity)) / 255;
        res.wr_en = 1'b1;
        res.addr  = 24'(ty * w + tx);
        if (a == 0)
            res.pixel = dst;
        else if (a == 255)
            res.pixel = {8'(a), src[23:0]};
        else
        begin
            res.pixel[31:24] = ALPHA_OPAQUE;
            for (int k = 0; k < 3; k++)
            begin
                s = int'(src[8*k +: 8]);
                d = int'(dst[8*k +: 8]);
                res.pixel[8*k +: 8] = 8'((s * a + d * (255 - a)) / 255);
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = 13'd640;
            height_reg = 13'd480;
            off_x      = '0;
            off_y      = '0;
            opacity    = ALPHA_OPAQUE;
            pending_writes.delete();
            pending    = 0;
        end
        else
        begin
            // track register writes
            if (cfg_we)
            begin
                case (abp_reg_t'(cfg_index))
                    REG_DEST_WIDTH:   width_reg  = cfg_data;
                    REG_DEST_HEIGHT:  height_reg = cfg_data;
                    REG_OFFSET_X:     off_x      = cfg_data;
                    REG_OFFSET_Y:     off_y      = cfg_data;
                    REG_OPACITY:      opacity    = cfg_data[7:0];
                    default: ;
                endcase
            end
            // predict the write word for each accepted pixel
            if (s_tvalid && s_tready)
                pending_writes.push_back(blend_write(s_tdata, s_tlast));
            // compare each output word with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.wr_en = m_tuser[0];
                got.addr  = m_tdata[23:0];
                got.pixel = m_tdata[55:24];
                got.last  = m_tlast;
                if (pending_writes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: unexpected word we=%0b addr=%h pix=%h last=%0b",
                                 $time, got.wr_en, got.addr, got.pixel, got.last);
                end
                else
                begin
                    want = pending_writes.pop_front();
                    if (got.wr_en !== want.wr_en || got.addr !== want.addr ||
                        got.pixel !== want.pixel || got.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                        begin
                            $display("%0t: mismatch want we=%0b addr=%h pix=%h last=%0b",
                                     $time, want.wr_en, want.addr, want.pixel, want.last);
                            $display("%0t:          got  we=%0b addr=%h pix=%h last=%0b",
                                     $time, got.wr_en, got.addr, got.pixel, got.last);
                        end
                    end
                end
            end
            pending = pending_writes.size();
        end
    end

endmodule

// ----- tb/sv/argb_alpha_blit_pixel_top_test.sv -----
// ----------------------------------------------------------------------------
// ARGB alpha blit pixel testbench
// Drives the blit pixel pipeline with directed corner pixels and random
// blits over a series of destination placements, sizes and opacities, with
// random idling on both stream sides. The checker predicts and compares.
// ----------------------------------------------------------------------------
module argb_alpha_blit_pixel_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import abp_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASES       = 11;
    localparam int PHASE_PIXELS = 50;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    int   fail_count;
    int   pending;
    int   cycles = 0;
    logic hold_request = 1'b0;
    logic no_stall = 1'b0;
    int   ready_run = 0;

    // current placement, used to aim coordinates at the destination box
    int w_eff = 640;
    int h_eff = 480;
    int cur_ox = 0;
    int cur_oy = 0;

    argb_alpha_blit_pixel_top #(
        .MAX_DIM(4096)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    argb_alpha_blit_pixel_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL argb_alpha_blit_pixel_top");
            $finish;
        end
    end

    // idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one pixel word, hold it until accepted, then idle for the given gap
    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                              input logic [31:0] src, input logic [31:0] dst,
                              input logic last, input int gap);
        s_tdata  <= {dst, src, row, col};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // drain the pipeline, then write all five registers back to back
    task automatic apply_config(input int w, input int h, input int ox, input int oy,
                                input int ga);
        abp_reg_t    regs[5];
        logic [12:0] vals[5];
        regs = '{REG_DEST_WIDTH, REG_DEST_HEIGHT, REG_OFFSET_X, REG_OFFSET_Y,
                 REG_OPACITY};
        vals = '{13'(w), 13'(h), 13'(ox), 13'(oy), 13'(ga)};
        while (pending != 0)
            @(negedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        w_eff  = (vals[0] > 4096) ? 4096 : int'(vals[0]);
        h_eff  = (vals[1] > 4096) ? 4096 : int'(vals[1]);
        cur_ox = ox;
        cur_oy = oy;
    endtask

    // receiver: random stalls, a long hold on request, steady phases
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready     <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (no_stall)
                m_tready <= 1'b1;
            else if (ready_run > 0)
                ready_run--;
            else if ($urandom_range(0, 2) == 0)
            begin
                m_tready  <= 1'b0;
                ready_run = idle_len();
            end
            else
            begin
                m_tready  <= 1'b1;
                ready_run = $urandom_range(0, 12);
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int          w;
        int          h;
        int          ox;
        int          oy;
        int          ga;
        int          tx;
        int          ty;
        int          col_i;
        int          row_i;
        int          gap;
        logic [7:0]  alpha;
        logic        last_flag;
        logic        pressure;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_DEST_WIDTH;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset placement: corners, clip edges and alpha extremes
        send_pixel(12'd0, 12'd0, 32'hFF123456, 32'h00ABCDEF, 1'b0, 0);
        send_pixel(12'd639, 12'd479, 32'h00FFFFFF, 32'h89ABCDEF, 1'b0, 1);
        send_pixel(12'd640, 12'd0, 32'h80FFFFFF, 32'h12345678, 1'b0, 0);
        send_pixel(12'd0, 12'd480, 32'h80FFFFFF, 32'h12345678, 1'b0, 0);
        send_pixel(12'hFFF, 12'hFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 2);
        send_pixel(12'd100, 12'd200, 32'h80FF8001, 32'h4000FF7F, 1'b0, 0);
        send_pixel(12'd1, 12'd1, 32'h01FFFFFF, 32'hFF000000, 1'b0, 0);
        send_pixel(12'd2, 12'd2, 32'hFE000000, 32'h00FFFFFF, 1'b0, 1);

        // zero opacity keeps the destination
        apply_config(640, 480, 0, 0, 0);
        send_pixel(12'd5, 12'd5, 32'hFFFFFFFF, 32'h12345678, 1'b0, 1);

        // half opacity scales an opaque source into a blend
        apply_config(640, 480, 0, 0, 128);
        send_pixel(12'd5, 12'd6, 32'hFF204060, 32'h00FFFFFF, 1'b0, 0);
        send_pixel(12'd5, 12'd7, 32'h00204060, 32'h00FFFFFF, 1'b0, 1);

        // oversized dimensions saturate; far corner hits the top address
        apply_config(8191, 8191, 4095, 0, 1);
        send_pixel(12'd0, 12'd4095, 32'hFF00FF00, 32'h11223344, 1'b0, 0);
        send_pixel(12'd1, 12'd4095, 32'hFF00FF00, 32'h11223344, 1'b0, 1);

        // most negative offset pushes every column off the left edge
        apply_config(4096, 4096, -4096, -4096, 255);
        send_pixel(12'hFFF, 12'hFFF, 32'hFFFFFFFF, 32'h0, 1'b1, 1);

        // zero width and zero height clip everything
        apply_config(0, 480, 0, 0, 255);
        send_pixel(12'd0, 12'd0, 32'hFF00FF00, 32'h55AA55AA, 1'b0, 1);
        apply_config(640, 0, 0, 0, 255);
        send_pixel(12'd0, 12'd0, 32'hFF00FF00, 32'h55AA55AA, 1'b1, 1);

        // random blits, one placement per phase
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                w = 640; h = 480; ox = 0; oy = 0; ga = 255;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: w = 1;
                    1: w = 4096;
                    2: w = 8191;
                    3: w = $urandom_range(1, 64);
                    default: w = $urandom_range(1, 4096);
                endcase
                case ($urandom_range(0, 5))
                    0: h = 1;
                    1: h = 4096;
                    2: h = 8191;
                    3: h = $urandom_range(1, 64);
                    default: h = $urandom_range(1, 4096);
                endcase
                if (p == 7)
                    w = 0;
                case ($urandom_range(0, 4))
                    0: ox = -4096;
                    1: ox = 4095;
                    2: ox = $urandom_range(0, 140) - 70;
                    default: ox = $urandom_range(0, 8191) - 4096;
                endcase
                case ($urandom_range(0, 4))
                    0: oy = -4096;
                    1: oy = 4095;
                    2: oy = $urandom_range(0, 140) - 70;
                    default: oy = $urandom_range(0, 8191) - 4096;
                endcase
                case ($urandom_range(0, 4))
                    0: ga = 255;
                    1: ga = 0;
                    2: ga = ($urandom_range(0, 1) == 0) ? 1 : 254;
                    default: ga = $urandom_range(0, 255);
                endcase
            end
            apply_config(w, h, ox, oy, ga);

            // phase 2 fills the pipeline against a held-off receiver
            pressure = (p == 2);
            if (pressure)
                hold_request = 1'b1;
            no_stall = (p == 4);

            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                // aim most pixels inside the destination box or just beyond its edges
                if ($urandom_range(0, 9) < 8)
                begin
                    tx    = $urandom_range(0, w_eff + 1) - 1;
                    col_i = tx - cur_ox;
                    if (col_i < 0 || col_i > 4095)
                        col_i = $urandom_range(0, 4095);
                end
                else
                    col_i = $urandom_range(0, 4095);
                if ($urandom_range(0, 9) < 8)
                begin
                    ty    = $urandom_range(0, h_eff + 1) - 1;
                    row_i = ty - cur_oy;
                    if (row_i < 0 || row_i > 4095)
                        row_i = $urandom_range(0, 4095);
                end
                else
                    row_i = $urandom_range(0, 4095);
                case ($urandom_range(0, 9))
                    0, 1: alpha = ALPHA_CLEAR;
                    2, 3: alpha = ALPHA_OPAQUE;
                    4: alpha = 8'h01;
                    5: alpha = 8'hFE;
                    default: alpha = 8'($urandom);
                endcase
                last_flag = (i == PHASE_PIXELS - 1) || ($urandom_range(0, 19) == 0);
                gap = pressure ? 0 : idle_len();
                // drop valid after the last word and before a mid-phase drain
                if (i == PHASE_PIXELS - 1 || (p == 5 && i == 25))
                    gap = gap + 1;
                send_pixel(12'(col_i), 12'(row_i), {alpha, 24'($urandom)}, $urandom,
                           last_flag, gap);
                // hold the sender until every word has come out
                if (p == 5 && i == 25)
                begin
                    while (pending != 0)
                        @(negedge clk);
                end
            end
        end
        no_stall = 1'b0;

        // drain and give the verdict
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("PASS argb_alpha_blit_pixel_top");
        else
            $display("FAIL argb_alpha_blit_pixel_top");
        $finish;
    end

endmodule
